// ===== rtl/edmt_pkg.sv =====
// Shared widths, limits, state codes and the result record of the egg drop core.
package edmt_pkg;

   localparam int EGGS_W         = 5;
   localparam int FLOORS_W       = 9;
   localparam int TRIALS_W       = 9;
   localparam int TRIALS_MAX     = 511;
   localparam int MAX_EGGS_DEF   = 16;
   localparam int MAX_FLOORS_DEF = 256;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CELL,
      ST_COPY,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                valid;
      logic [TRIALS_W-1:0] trials;
   } res_type;

endpackage

// ===== rtl/edmt_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
interface edmt_req_if;
   logic                          valid;
   logic                          ready;
   logic [edmt_pkg::EGGS_W-1:0]   eggs;
   logic [edmt_pkg::FLOORS_W-1:0] floors;

   modport source (output valid, output eggs, output floors, input ready);
   modport sink (input valid, input eggs, input floors, output ready);
endinterface

interface edmt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [edmt_pkg::TRIALS_W-1:0] trials;

   modport source (output valid, output trials, input ready);
   modport sink (input valid, input trials, output ready);
endinterface

// ===== rtl/edmt_row_ram.sv =====
// One-write one-read synchronous RAM holding one row of the drop table.
module edmt_row_ram #(
   parameter int DEPTH  = 257,
   parameter int ADDR_W = 9,
   parameter int DATA_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/edmt_solver.sv =====
// Row-by-row sequencer: scans the two row memories and builds each table entry.
module edmt_solver #(
   parameter int MAX_EGGS   = edmt_pkg::MAX_EGGS_DEF,
   parameter int MAX_FLOORS = edmt_pkg::MAX_FLOORS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [edmt_pkg::EGGS_W-1:0]   eggs,
   input  logic [edmt_pkg::FLOORS_W-1:0] floors,
   output edmt_pkg::res_type             res,
   input  logic                          res_ready
);
   import edmt_pkg::*;

   localparam int DEPTH  = MAX_FLOORS + 1;
   localparam int ADDR_W = $clog2(MAX_FLOORS + 1);
   localparam int VAL_W  = ADDR_W;
   localparam int EGG_W  = $clog2(MAX_EGGS + 1);

   state_type           state_ff, state_in;
   logic [EGG_W-1:0]    eggs_ff, eggs_in;
   logic [ADDR_W-1:0]   floors_ff, floors_in;
   logic [EGG_W-1:0]    row_ff, row_in;
   logic [ADDR_W-1:0]   f_ff, f_in;
   logic [ADDR_W-1:0]   x_ff, x_in;
   logic [VAL_W-1:0]    best_ff, best_in;
   logic                pv_ff, pv_in;
   logic [TRIALS_W-1:0] res_ff, res_in;

   logic [EGG_W-1:0]  eggs_c;
   logic [ADDR_W-1:0] floors_c;

   logic              bank;
   logic              we;
   logic [VAL_W-1:0]  wdata;
   logic [ADDR_W-1:0] prev_raddr, cur_raddr;
   logic [ADDR_W-1:0] raddr0, raddr1;
   logic [VAL_W-1:0]  rd0, rd1;
   logic [VAL_W-1:0]  prev_rd, cur_rd;
   logic [VAL_W-1:0]  v_max, v_min;
   logic              commit;
   logic [VAL_W-1:0]  cval;

   // clamp the request to the table size
   always_comb begin
      eggs_c   = (32'(eggs) > 32'(MAX_EGGS)) ? EGG_W'(MAX_EGGS) : EGG_W'(eggs);
      floors_c = (32'(floors) > 32'(MAX_FLOORS)) ? ADDR_W'(MAX_FLOORS) : ADDR_W'(floors);
   end

   // odd rows write bank 1, even rows bank 0; the other bank holds the row above
   assign bank    = row_ff[0];
   assign raddr0  = bank ? prev_raddr : cur_raddr;
   assign raddr1  = bank ? cur_raddr : prev_raddr;
   assign prev_rd = bank ? rd0 : rd1;
   assign cur_rd  = bank ? rd1 : rd0;
   assign v_max   = (prev_rd > cur_rd) ? prev_rd : cur_rd;
   assign v_min   = (v_max < best_ff) ? v_max : best_ff;

   edmt_row_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (VAL_W)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (we && !bank),
      .wr_addr (f_ff),
      .wr_data (wdata),
      .rd_addr (raddr0),
      .rd_data (rd0)
   );

   edmt_row_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (VAL_W)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (we && bank),
      .wr_addr (f_ff),
      .wr_data (wdata),
      .rd_addr (raddr1),
      .rd_data (rd1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv_ff    <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      eggs_ff   <= eggs_in;
      floors_ff <= floors_in;
      row_ff    <= row_in;
      f_ff      <= f_in;
      x_ff      <= x_in;
      best_ff   <= best_in;
      res_ff    <= res_in;
   end

   always_comb begin
      state_in   = state_ff;
      eggs_in    = eggs_ff;
      floors_in  = floors_ff;
      row_in     = row_ff;
      f_in       = f_ff;
      x_in       = x_ff;
      best_in    = best_ff;
      res_in     = res_ff;
      pv_in      = 1'b0;
      req_ready  = 1'b0;
      res.valid  = 1'b0;
      res.trials = res_ff;
      we         = 1'b0;
      wdata      = '0;
      prev_raddr = x_ff - ADDR_W'(1);
      cur_raddr  = f_ff - x_ff;
      commit     = 1'b0;
      cval       = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               eggs_in   = eggs_c;
               floors_in = floors_c;
               row_in    = EGG_W'(1);
               f_in      = '0;
               if (eggs_c == '0) begin
                  // no eggs: one floor still takes a drop
                  res_in   = (floors_c == ADDR_W'(1)) ? TRIALS_W'(1) : '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_CELL;
               end
            end
         end
         ST_CELL: begin
            if (row_ff == EGG_W'(1) || f_ff < ADDR_W'(2)) begin
               commit = 1'b1;
               cval   = f_ff;
            end else if (32'(row_ff) > 32'(f_ff)) begin
               prev_raddr = f_ff;
               state_in   = ST_COPY;
            end else begin
               x_in     = ADDR_W'(1);
               best_in  = '1;
               state_in = ST_SCAN;
            end
         end
         ST_COPY: begin
            commit = 1'b1;
            cval   = prev_rd;
         end
         ST_SCAN: begin
            // issue one drop floor per cycle, fold last cycle's read data
            pv_in = 1'b1;
            if (pv_ff) begin
               best_in = v_min;
            end
            x_in = x_ff + ADDR_W'(1);
            if (x_ff == f_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            commit = 1'b1;
            cval   = v_min + VAL_W'(1);
         end
         ST_DONE: begin
            res.valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (commit) begin
         we    = 1'b1;
         wdata = cval;
         if (f_ff == floors_ff) begin
            if (row_ff == eggs_ff) begin
               res_in   = (32'(cval) > 32'(TRIALS_MAX)) ? TRIALS_W'(TRIALS_MAX)
                                                        : TRIALS_W'(cval);
               state_in = ST_DONE;
            end else begin
               row_in   = row_ff + EGG_W'(1);
               f_in     = '0;
               state_in = ST_CELL;
            end
         end else begin
            f_in     = f_ff + ADDR_W'(1);
            state_in = ST_CELL;
         end
      end
   end

endmodule

// ===== rtl/egg_drop_min_trials_core.sv =====
// Top level of the egg drop minimum-trials core: solver plus response register.
//
//   channel  direction  payload              handshake
//   req_bus  in         eggs[4:0] floors[8:0] valid/ready
//   rsp_bus  out        trials[8:0]          valid/ready
//
// One request at a time. Zero eggs goes from idle straight to the done state and
// then to the response register; otherwise the run for E eggs and F >= 2 floors is
// set by the min scan, one compare per cycle through the two row memories.
// Synchronous reset returns the sequencer to idle and empties the response
// register; the row memories are scratch and need no clearing.
// A stalled response holds in its register while the next request is solved.
module egg_drop_min_trials_core #(
   parameter int MAX_EGGS   = edmt_pkg::MAX_EGGS_DEF,
   parameter int MAX_FLOORS = edmt_pkg::MAX_FLOORS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   edmt_req_if.sink   req_bus,
   edmt_rsp_if.source rsp_bus
);
   import edmt_pkg::*;

   res_type             res;
   logic                res_ready;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TRIALS_W-1:0] rsp_trials_ff, rsp_trials_in;

   edmt_solver #(
      .MAX_EGGS   (MAX_EGGS),
      .MAX_FLOORS (MAX_FLOORS)
   ) u_solver (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .eggs      (req_bus.eggs),
      .floors    (req_bus.floors),
      .res       (res),
      .res_ready (res_ready)
   );

   assign res_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_trials_in = rsp_trials_ff;
      if (res_ready) begin
         rsp_valid_in  = res.valid;
         rsp_trials_in = res.trials;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_trials_ff <= rsp_trials_in;
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.trials = rsp_trials_ff;

endmodule

// ===== rtl/edmt_checker.sv =====
// Port-level assertions for the egg drop core and their bind to the top level.
module edmt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [edmt_pkg::EGGS_W-1:0]   req_eggs,
   input logic [edmt_pkg::FLOORS_W-1:0] req_floors,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [edmt_pkg::TRIALS_W-1:0] rsp_trials
);
   import edmt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_trials))
      else $error("response dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in work");

   a_zero_eggs: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_eggs == '0 && !rsp_valid |=> ##1
         rsp_valid && rsp_trials == (($past(req_floors, 2) == FLOORS_W'(1))
                                     ? TRIALS_W'(1) : TRIALS_W'(0)))
      else $error("zero-egg request answered wrongly or late");

endmodule

bind egg_drop_min_trials_core edmt_checker u_edmt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_eggs   (req_bus.eggs),
   .req_floors (req_bus.floors),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_trials (rsp_bus.trials)
);

// ===== bench/tb_egg_drop_min_trials_core.sv =====
// Testbench for the egg drop core: directed and random queries checked against a predictor.
`timescale 1ns / 1ps

module tb_egg_drop_min_trials_core;
   import edmt_pkg::*;

   localparam int RANDOM_QUERIES = 78;
   localparam int IDLE_PERCENT   = 17;
   localparam int DRAIN_CYCLES   = 50;
   // slowest query (16 eggs, 256 floors) is solved with no handshake on either side
   localparam int QUIET_LIMIT    = 2_000_000;

   typedef struct packed {
      logic [EGGS_W-1:0]   eggs;
      logic [FLOORS_W-1:0] floors;
      logic                known;
      logic [TRIALS_W-1:0] trials;
   } query_row_type;

   logic clock;
   logic reset;
   bit   calm;
   int   mismatches;
   int   quiet_cycles;

   logic [TRIALS_W-1:0] trials_due[$];

   // known answers typed in; the rest go through the predictor
   query_row_type directed_rows [0:21] = '{
      '{5'd0,  9'd0,   1'b1, 9'd0},
      '{5'd0,  9'd1,   1'b1, 9'd1},
      '{5'd0,  9'd2,   1'b1, 9'd0},
      '{5'd0,  9'd511, 1'b1, 9'd0},
      '{5'd1,  9'd0,   1'b1, 9'd0},
      '{5'd1,  9'd1,   1'b1, 9'd1},
      '{5'd1,  9'd256, 1'b1, 9'd256},
      '{5'd1,  9'd511, 1'b1, 9'd256},
      '{5'd31, 9'd0,   1'b1, 9'd0},
      '{5'd31, 9'd1,   1'b1, 9'd1},
      '{5'd17, 9'd2,   1'b0, 9'd0},
      '{5'd16, 9'd3,   1'b0, 9'd0},
      '{5'd5,  9'd4,   1'b0, 9'd0},
      '{5'd2,  9'd2,   1'b0, 9'd0},
      '{5'd2,  9'd100, 1'b0, 9'd0},
      '{5'd2,  9'd36,  1'b0, 9'd0},
      '{5'd3,  9'd14,  1'b0, 9'd0},
      '{5'd4,  9'd20,  1'b0, 9'd0},
      '{5'd8,  9'd10,  1'b0, 9'd0},
      '{5'd30, 9'd16,  1'b0, 9'd0},
      '{5'd0,  9'd256, 1'b1, 9'd0},
      '{5'd16, 9'd256, 1'b1, 9'd9}
   };

   edmt_req_if req_bus ();
   edmt_rsp_if rsp_bus ();

   egg_drop_min_trials_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bottom-up table over two rows; eggs and floors clamp to the build limits.
   function automatic logic [TRIALS_W-1:0] min_drops(input logic [EGGS_W-1:0] eggs_in,
                                                     input logic [FLOORS_W-1:0] floors_in);
      int unsigned egg_cnt;
      int unsigned floor_cnt;
      int unsigned best;
      int unsigned cand;
      int unsigned prior [0:MAX_FLOORS_DEF];
      int unsigned row [0:MAX_FLOORS_DEF];
      egg_cnt   = (int'(eggs_in) > MAX_EGGS_DEF) ? MAX_EGGS_DEF : int'(eggs_in);
      floor_cnt = (int'(floors_in) > MAX_FLOORS_DEF) ? MAX_FLOORS_DEF : int'(floors_in);
      if (egg_cnt == 0) begin
         return (floor_cnt == 1) ? TRIALS_W'(1) : TRIALS_W'(0);
      end
      for (int f = 0; f <= floor_cnt; f++) prior[f] = f;
      for (int e = 2; e <= egg_cnt; e++) begin
         row[0] = 0;
         if (floor_cnt >= 1) row[1] = 1;
         for (int f = 2; f <= floor_cnt; f++) begin
            if (e > f) begin
               row[f] = prior[f];
            end else begin
               best = 32'hFFFF_FFFF;
               for (int x = 1; x <= f; x++) begin
                  cand = (prior[x-1] > row[f-x]) ? prior[x-1] : row[f-x];
                  if (cand < best) best = cand;
               end
               row[f] = best + 1;
            end
         end
         prior = row;
      end
      return (prior[floor_cnt] > TRIALS_MAX) ? TRIALS_W'(TRIALS_MAX)
                                             : TRIALS_W'(prior[floor_cnt]);
   endfunction

   task automatic report_mismatch(input string what, input logic [TRIALS_W-1:0] got,
                                  input logic [TRIALS_W-1:0] want);
      $display("[%0t] %s: trials got %0d want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic send_query(input logic [EGGS_W-1:0] eggs, input logic [FLOORS_W-1:0] floors,
                             input logic known, input logic [TRIALS_W-1:0] trials);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.eggs   <= eggs;
      req_bus.floors <= floors;
      do @(posedge clock); while (!req_bus.ready);
      trials_due.push_back(known ? trials : min_drops(eggs, floors));
   endtask

   // response side: check accepted results, then pick the next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (trials_due.size() == 0) begin
               report_mismatch("response with no request pending", rsp_bus.trials, '0);
            end else begin
               if (rsp_bus.trials !== trials_due[0])
                  report_mismatch("wrong answer", rsp_bus.trials, trials_due[0]);
               void'(trials_due.pop_front());
            end
         end
         rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [EGGS_W-1:0]   eggs;
      logic [FLOORS_W-1:0] floors;
      int                  pick;
      clock          = 1'b0;
      reset          = 1'b1;
      calm           = 1'b0;
      req_bus.valid  = 1'b0;
      req_bus.eggs   = '0;
      req_bus.floors = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_query(directed_rows[i].eggs, directed_rows[i].floors,
                    directed_rows[i].known, directed_rows[i].trials);

      for (int n = 0; n < RANDOM_QUERIES; n++) begin
         // hold both sides busy for a stretch
         calm = (n >= 40 && n < 60);
         pick = $urandom_range(99);
         if (pick < 8) begin
            // few eggs keeps the full floor range affordable
            eggs   = EGGS_W'($urandom_range(2, 1));
            floors = FLOORS_W'($urandom_range(511, 0));
         end else if (pick < 38) begin
            eggs   = EGGS_W'($urandom_range(31, 0));
            floors = FLOORS_W'($urandom_range(40, 0));
         end else begin
            eggs   = EGGS_W'($urandom);
            floors = FLOORS_W'($urandom_range(16, 0));
         end
         send_query(eggs, floors, 1'b0, '0);
      end
      calm = 1'b0;
      req_bus.valid <= 1'b0;

      while (trials_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
